// File: hdl/b64e_pkg.sv
// Shared types, constants and the character table for the base64 stream encoder.
package b64e_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam logic [7:0] PAD_CHAR = 8'd61;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} out_item_t;

	typedef enum logic [1:0] {
		GP_0 = 2'd0,
		GP_1 = 2'd1,
		GP_2 = 2'd2
	} grp_pos_t;

	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            last;
	} job_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'd65 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'd97 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'd48 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'd43;
		end else begin
			c = 8'd47;
		end
		return c;
	endfunction

endpackage

// File: hdl/b64e_front.sv
// Front end: takes raw bytes, tracks group position and carry, builds character jobs.
module b64e_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  b64e_pkg::in_item_t  byte_req,
	input  logic                job_full,
	output logic                job_push,
	output b64e_pkg::job_t      job_data
);
	import b64e_pkg::*;

	grp_pos_t   pos_q, pos_d;
	logic [3:0] carry_q, carry_d;
	logic       accept;
	logic [7:0] b;

	assign byte_ready = !job_full;
	assign accept     = byte_valid && byte_ready;
	assign job_push   = accept;
	assign b          = byte_req.in_byte;

	always_comb begin
		pos_d   = pos_q;
		carry_d = carry_q;
		unique case (pos_q)
			GP_1: begin
				pos_d   = byte_req.in_last ? GP_0 : GP_2;
				carry_d = byte_req.in_last ? 4'd0 : b[3:0];
			end
			GP_2: begin
				pos_d   = GP_0;
				carry_d = 4'd0;
			end
			default: begin
				pos_d   = byte_req.in_last ? GP_0 : GP_1;
				carry_d = byte_req.in_last ? 4'd0 : {2'b00, b[1:0]};
			end
		endcase
	end

	always_comb begin
		job_data.chars[2] = PAD_CHAR;
		job_data.chars[3] = PAD_CHAR;
		job_data.last     = byte_req.in_last;
		unique case (pos_q)
			GP_1: begin
				job_data.chars[0] = b64_char({carry_q[1:0], b[7:4]});
				job_data.chars[1] = b64_char({b[3:0], 2'b00});
				job_data.last_idx = byte_req.in_last ? 2'd2 : 2'd0;
			end
			GP_2: begin
				job_data.chars[0] = b64_char({carry_q, b[7:6]});
				job_data.chars[1] = b64_char(b[5:0]);
				job_data.last_idx = 2'd1;
			end
			default: begin
				job_data.chars[0] = b64_char(b[7:2]);
				job_data.chars[1] = b64_char({b[1:0], 4'b0000});
				job_data.last_idx = byte_req.in_last ? 2'd3 : 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= GP_0;
			carry_q <= 4'd0;
		end else if (accept) begin
			pos_q   <= pos_d;
			carry_q <= carry_d;
		end
	end

endmodule

// File: hdl/b64e_queue.sv
// Short job queue between the front end and the character emitter.
module b64e_queue #(
	parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64e_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output b64e_pkg::job_t head
);
	import b64e_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/b64e_back.sv
// Back end: walks each queued job one character per cycle into the output register while char_ready allows.
module b64e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  b64e_pkg::job_t      job_head,
	output logic                job_pop,
	output logic                char_valid,
	input  logic                char_ready,
	output b64e_pkg::out_item_t char_req
);
	import b64e_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       load;
	logic       at_end;

	assign load       = job_valid && (!out_valid_q || char_ready);
	assign at_end     = (idx_q == job_head.last_idx);
	assign job_pop    = load && at_end;
	assign char_valid = out_valid_q;
	assign char_req   = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_char <= job_head.chars[idx_q];
			out_q.out_last <= job_head.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/base64_stream_encoder.sv
// Top level of the streaming base64 encoder (standard alphabet, '=' padding).
//
// Byte channel: byte_valid/byte_ready carry one raw byte per request, with
// in_last set on the final byte of a message. Character channel:
// char_valid/char_ready carry one ASCII character per request, with out_last
// set on the final character of the encoded message.
// A byte yields one or two characters; the last byte of a message yields two,
// three or four, and the group is padded with '=' to four characters.
// A byte passes the job queue and the output register before its first
// character shows. The output channel moves one character per cycle while
// char_ready is high, so three bytes give four characters in a steady stream;
// a byte is accepted every cycle while the job queue has room. The output
// register is the rate limit. The front end accepts bytes whenever the job
// queue between the front end and the character emitter has room, so input
// keeps flowing while the receiver stalls until QUEUE_DEPTH jobs are waiting.
// Reset clears the group position, the carry bits, the queue and the
// output valid; the next byte after reset starts a new message.
module base64_stream_encoder #(
	parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  b64e_pkg::in_item_t  byte_req,
	output logic                char_valid,
	input  logic                char_ready,
	output b64e_pkg::out_item_t char_req
);
	import b64e_pkg::*;

	job_t push_data;
	job_t head;
	logic push, full, pop, not_empty;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_req   (byte_req),
		.job_full   (full),
		.job_push   (push),
		.job_data   (push_data)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (not_empty),
		.job_head   (head),
		.job_pop    (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_req   (char_req)
	);

endmodule

// File: hdl/b64e_checker.sv
// Port-level checker for the base64 stream encoder, bound to the top level.
module b64e_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                char_valid,
	input logic                char_ready,
	input b64e_pkg::out_item_t char_req
);
	import b64e_pkg::*;

	logic [1:0] grp_q;
	logic       acc;

	assign acc = char_valid && char_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= 2'd0;
		end else if (acc) begin
			grp_q <= char_req.out_last ? 2'd0 : grp_q + 2'd1;
		end
	end

	// A message always ends on a whole four-character group.
	a_last_on_group_end: assert property (@(posedge clk) disable iff (!arst_n)
		acc && char_req.out_last |-> grp_q == 2'd3)
		else $error("final character not at the end of a group");

	// Padding only appears in the last two places of a group.
	a_pad_place: assert property (@(posedge clk) disable iff (!arst_n)
		acc && char_req.out_char == PAD_CHAR |-> grp_q[1])
		else $error("pad character early in a group");

	// A stalled character holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_ready |=> char_valid && $stable(char_req))
		else $error("character changed while stalled");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_ready (char_ready),
	.char_req   (char_req)
);
